/* src/lfia_pkg.sv */
`timescale 1ns / 1ps
// lfia_pkg: shared types, constants and search functions of the id allocator
// used by lfia_dp, lfia_ctrl and lowest_free_id_allocator_core; no dependencies

package lfia_pkg;

  // identifier and map geometry
  localparam int ID_W       = 12;
  localparam int MARK_W     = ID_W + 1;
  localparam int MAP_DEPTH  = 4096;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NWORDS     = MAP_DEPTH / WORD_W;
  localparam int WIDX_W     = $clog2(NWORDS);
  localparam int POOL_SIZE  = 4096;
  localparam int POOL_LIMIT = (POOL_SIZE < MAP_DEPTH) ? POOL_SIZE : MAP_DEPTH;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_e;

  typedef struct packed {
    mode_e           mode;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    status_e         status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_FETCH,
    S_MODIFY,
    S_MARK,
    S_WALK,
    S_WRITE,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_FETCH,
    OP_MODIFY,
    OP_MARK,
    OP_WALK,
    OP_WRITE,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic summary_any;
    logic rel_bad;
    logic rel_top;
    logic walk_more;
    logic walk_cross;
  } sts_t;

  // lowest set bit of a map word
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // lowest word that holds a free identifier
  function automatic logic [WIDX_W-1:0] lowest_word(input logic [NWORDS-1:0] v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WIDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* src/lowest_free_id_allocator_core.sv */
`timescale 1ns / 1ps
// lowest_free_id_allocator_core: top level of the lowest-free id allocator
// depends on lfia_pkg, lfia_ctrl, lfia_dp (and lfia_ram through lfia_dp)
//
//   channel  | signals                           | direction | transfer when
//   ---------+-----------------------------------+-----------+----------------------
//   request  | in_valid_i, in_stall_o, in_data_i | in        | valid high, stall low
//   response | out_valid_o, out_stall_i, out_data_o | out    | valid high, stall low
//
// sequence: one request at a time; an allocate that reuses a freed id reads,
//   fetches, modifies and writes a map word, while handing out the high-water
//   mark takes only the mark step; a release reads, fetches and modifies (a
//   rejected one stops there), walks the mark down over free ids when it was
//   the top id, re-reading each map word crossed from the registered map ram, then writes
// reset clears the mark and the per-word summary; no clearing pass over the ram
// the response sits in an output register, so a new request is taken while
//   the previous response is still stalled

module lowest_free_id_allocator_core import lfia_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  // controller to datapath command, datapath to controller status
  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per datapath step
  lfia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // free map words in ram, a summary bit per word marks any free id in it;
  // a word whose summary bit is clear reads as empty, so the ram needs no init
  lfia_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

/* src/lfia_ram.sv */
`timescale 1ns / 1ps
// lfia_ram: generic single-write, single-read ram with registered read data
// no dependencies

module lfia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lfia_dp.sv */
`timescale 1ns / 1ps
// lfia_dp: datapath of the id allocator: free map ram, word summary, mark, result
// depends on lfia_pkg and lfia_ram

module lfia_dp import lfia_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t in_data_i,
  output sts_t sts_o,
  output rsp_t out_data_o
);

  mode_e             mode_q, mode_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [MARK_W-1:0] mark_q, mark_d;
  logic [NWORDS-1:0] summary_q, summary_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  status_e           res_st_q, res_st_d;
  rsp_t              out_q, out_d;

  logic [WORD_W-1:0] ram_rdata;
  logic [BIT_W-1:0]  bit_idx;
  logic [BIT_W-1:0]  free_bit;
  logic [MARK_W-1:0] mark_m1;
  logic [MARK_W-1:0] id_ext;
  logic              rel_bad;
  logic              rel_top;
  logic              walk_more;
  logic              walk_cross;
  logic              exhausted;

  assign bit_idx    = id_q[BIT_W-1:0];
  assign free_bit   = lowest_bit(word_q);
  assign mark_m1    = mark_q - MARK_W'(1);
  assign id_ext     = {1'b0, id_q};
  assign rel_bad    = (id_ext >= mark_q) || word_q[bit_idx];
  assign rel_top    = (id_ext == mark_m1);
  assign walk_more  = (mark_q != '0) && word_q[mark_m1[BIT_W-1:0]];
  assign walk_cross = (mark_m1[BIT_W-1:0] == '0) && (mark_m1 != '0);
  assign exhausted  = (mark_q >= MARK_W'(POOL_LIMIT));

  assign sts_o = '{
    is_release:  (mode_q == MODE_RELEASE),
    summary_any: (summary_q != '0),
    rel_bad:     rel_bad,
    rel_top:     rel_top,
    walk_more:   walk_more,
    walk_cross:  walk_cross
  };

  always_comb begin
    mode_d    = mode_q;
    id_d      = id_q;
    widx_d    = widx_q;
    word_d    = word_q;
    mark_d    = mark_q;
    summary_d = summary_q;
    res_id_d  = res_id_q;
    res_st_d  = res_st_q;
    out_d     = out_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        mode_d   = in_data_i.mode;
        id_d     = in_data_i.release_id;
        widx_d   = (in_data_i.mode == MODE_RELEASE) ?
                   in_data_i.release_id[ID_W-1:BIT_W] : lowest_word(summary_q);
        res_id_d = '0;
        res_st_d = ST_OK;
      end
      OP_FETCH: begin
        // a word with no free entry is not trusted from the ram
        word_d = summary_q[widx_q] ? ram_rdata : '0;
      end
      OP_MODIFY: begin
        if (mode_q == MODE_ALLOC) begin
          word_d[free_bit] = 1'b0;
          res_id_d         = {widx_q, free_bit};
        end else if (rel_bad) begin
          res_st_d = ST_BAD_RELEASE;
        end else begin
          word_d[bit_idx] = 1'b1;
        end
      end
      OP_MARK: begin
        if (exhausted) begin
          res_st_d = ST_EXHAUSTED;
        end else begin
          res_id_d = mark_q[ID_W-1:0];
          mark_d   = mark_q + MARK_W'(1);
        end
      end
      OP_WALK: begin
        if (walk_more) begin
          word_d[mark_m1[BIT_W-1:0]] = 1'b0;
          mark_d                     = mark_m1;
          if (walk_cross) begin
            // the word left behind lies wholly above the mark, so it is empty
            summary_d[widx_q] = 1'b0;
            widx_d            = widx_q - WIDX_W'(1);
          end
        end
      end
      OP_WRITE: begin
        summary_d[widx_q] = |word_q;
      end
      OP_OUT: begin
        out_d = '{granted_id: res_id_q, status: res_st_q};
      end
      OP_NONE, OP_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q    <= '0;
      summary_q <= '0;
    end else begin
      mark_q    <= mark_d;
      summary_q <= summary_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    id_q     <= id_d;
    widx_q   <= widx_d;
    word_q   <= word_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    out_q    <= out_d;
  end

  lfia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_WRITE),
    .waddr_i (widx_q),
    .wdata_i (word_q),
    .re_i    (cmd_i.op == OP_READ),
    .raddr_i (widx_q),
    .rdata_o (ram_rdata)
  );

  assign out_data_o = out_q;

endmodule

/* src/lfia_ctrl.sv */
`timescale 1ns / 1ps
// lfia_ctrl: sequencer of the id allocator, drives datapath ops and handshakes
// depends on lfia_pkg

module lfia_ctrl import lfia_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   walking_q, walking_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d   = state_q;
    walking_d = walking_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d   = S_DISPATCH;
          walking_d = 1'b0;
        end
      end
      S_DISPATCH: begin
        if (!sts_i.is_release && !sts_i.summary_any) begin
          state_d = S_MARK;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_FETCH;
      S_FETCH: state_d = walking_q ? S_WALK : S_MODIFY;
      S_MODIFY: begin
        priority if (!sts_i.is_release) begin
          state_d = S_WRITE;
        end else if (sts_i.rel_bad) begin
          state_d = S_FINISH;
        end else if (sts_i.rel_top) begin
          state_d   = S_WALK;
          walking_d = 1'b1;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_MARK: state_d = S_FINISH;
      S_WALK: begin
        priority if (!sts_i.walk_more) begin
          state_d = S_WRITE;
        end else if (sts_i.walk_cross) begin
          state_d = S_READ;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WRITE: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_DISPATCH: cmd_o.op = OP_NONE;
      S_READ:     cmd_o.op = OP_READ;
      S_FETCH:    cmd_o.op = OP_FETCH;
      S_MODIFY:   cmd_o.op = OP_MODIFY;
      S_MARK:     cmd_o.op = OP_MARK;
      S_WALK:     cmd_o.op = OP_WALK;
      S_WRITE:    cmd_o.op = OP_WRITE;
      S_FINISH: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walking_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walking_q   <= walking_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench of lowest_free_id_allocator_core
// depends on lfia_pkg and the allocator rtl; keeps its own copy of the id map and mark

module tb;
  import lfia_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // request side, driven by the sender
  logic req_valid = 1'b0;
  req_t req_data = '0;
  logic req_stall;

  // response side, stall driven by the checker
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  // both sides stop idling while this is set
  bit steady = 1'b0;
  int err_count = 0;

  // expected responses, oldest first
  rsp_t expected_grants[$];
  // ids currently handed out, used to pick sensible releases
  int held_ids[$];

  // shadow allocator state
  bit id_free[MAP_DEPTH];
  int water_mark = 0;

  lowest_free_id_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shadow allocator: lowest free id below the mark first, else the mark itself;
  // a release frees the id and pulls the mark down over any free ids below it
  function automatic rsp_t compute_grant(input req_t r);
    rsp_t g;
    bit hit;
    int k;
    g.granted_id = '0;
    g.status = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      hit = 1'b0;
      for (k = 0; k < water_mark && !hit; k++) begin
        if (id_free[k]) begin
          id_free[k] = 1'b0;
          g.granted_id = ID_W'(k);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (water_mark >= POOL_LIMIT) begin
          g.status = ST_EXHAUSTED;
        end else begin
          g.granted_id = ID_W'(water_mark);
          water_mark++;
        end
      end
    end else begin
      if (int'(r.release_id) >= water_mark || id_free[r.release_id]) begin
        g.status = ST_BAD_RELEASE;
      end else begin
        id_free[r.release_id] = 1'b1;
        while (water_mark > 0 && id_free[water_mark - 1]) begin
          id_free[water_mark - 1] = 1'b0;
          water_mark--;
        end
      end
    end
    return g;
  endfunction

  // response checker and receiver stall, both on the rising edge
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid && !rsp_stall) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected response: granted_id %0d status %0d",
               rsp_data.granted_id, rsp_data.status);
        err_count++;
      end else begin
        want = expected_grants[0];
        expected_grants.delete(0);
        if (rsp_data.granted_id !== want.granted_id) begin
          $error("granted_id mismatch: expected %0d, actual %0d",
                 want.granted_id, rsp_data.granted_id);
          err_count++;
        end
        if (rsp_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 want.status, rsp_data.status);
          err_count++;
        end
      end
    end
    rsp_stall <= !steady && ($urandom_range(0, 99) < 12);
  end

  // one request transfer; called at a rising edge and returns at the accepting edge
  task automatic send_req(input mode_e m, input logic [ID_W-1:0] id, output rsp_t g);
    req_t r;
    int k;
    r.mode = m;
    r.release_id = id;
    while (!steady && $urandom_range(0, 99) < 12) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    g = compute_grant(r);
    expected_grants.insert(expected_grants.size(), g);
    if (g.status == ST_OK) begin
      if (m == MODE_ALLOC) begin
        held_ids.insert(held_ids.size(), int'(g.granted_id));
      end else begin
        for (k = 0; k < held_ids.size(); k++) begin
          if (held_ids[k] == int'(id)) begin
            held_ids.delete(k);
            break;
          end
        end
      end
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
  endtask

  task automatic drain_grants();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_grants.size() != 0) @(posedge clk_i);
  endtask

  // small hand-built sequence: releases on an empty pool, reuse of freed ids,
  // double release, release at the mark and a walk of the mark down to zero
  task automatic test_basic_sequence();
    rsp_t g;
    send_req(MODE_RELEASE, '0, g);
    send_req(MODE_RELEASE, 12'hFFF, g);
    send_req(MODE_ALLOC, 12'hFFF, g);
    send_req(MODE_ALLOC, 12'h555, g);
    send_req(MODE_RELEASE, 12'd1, g);
    send_req(MODE_RELEASE, 12'd1, g);
    send_req(MODE_RELEASE, 12'd0, g);
    send_req(MODE_ALLOC, 12'hAAA, g);
    send_req(MODE_ALLOC, '0, g);
    send_req(MODE_ALLOC, 12'h800, g);
    send_req(MODE_ALLOC, 12'h001, g);
    send_req(MODE_RELEASE, 12'd1, g);
    send_req(MODE_RELEASE, 12'd1, g);
    send_req(MODE_ALLOC, 12'h7FF, g);
    send_req(MODE_RELEASE, 12'd2, g);
    send_req(MODE_RELEASE, 12'd1, g);
    send_req(MODE_RELEASE, 12'd3, g);
    send_req(MODE_RELEASE, 12'd0, g);
    drain_grants();
  endtask

  // fill the whole pool, hit exhaustion, churn random ids, then hand everything back
  task automatic test_pool_exhaustion();
    rsp_t g;
    int k;
    repeat (POOL_LIMIT) send_req(MODE_ALLOC, ID_W'($urandom_range(0, 4095)), g);
    send_req(MODE_ALLOC, '0, g);
    send_req(MODE_ALLOC, 12'hFFF, g);
    repeat (40) send_req(MODE_RELEASE,
                         ID_W'(held_ids[$urandom_range(0, held_ids.size() - 1)]), g);
    repeat (42) send_req(MODE_ALLOC, ID_W'($urandom_range(0, 4095)), g);
    // ascending order so the last release walks the mark over the whole map
    for (k = 0; k < MAP_DEPTH; k++) begin
      if (k < water_mark && !id_free[k]) send_req(MODE_RELEASE, ID_W'(k), g);
    end
    drain_grants();
  endtask

  // random mix with a working set whose size changes every hundred items
  task automatic test_random_churn(input int n_ok);
    rsp_t g;
    int cap;
    int roll;
    int n;
    int i;
    cap = 8;
    n = 0;
    i = 0;
    while (n < n_ok) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: cap = 4;
          1: cap = 40;
          2: cap = 200;
          default: cap = 600;
        endcase
      end
      steady = (i >= 300 && i < 420);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_req(MODE_RELEASE, ID_W'($urandom_range(0, 4095)), g);
      end else if (roll < 12) begin
        send_req(MODE_RELEASE, ID_W'($urandom_range(0, water_mark)), g);
      end else if (held_ids.size() == 0 ||
                   (held_ids.size() < cap ? roll < 60 : roll < 30)) begin
        send_req(MODE_ALLOC, ID_W'($urandom_range(0, 4095)), g);
      end else begin
        send_req(MODE_RELEASE,
                 ID_W'(held_ids[$urandom_range(0, held_ids.size() - 1)]), g);
      end
      if (g.status == ST_OK) n++;
      i++;
    end
    steady = 1'b0;
    drain_grants();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_sequence();
    test_pool_exhaustion();
    test_random_churn(800);
    repeat (16) @(posedge clk_i);
    if (err_count == 0 && expected_grants.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
src/lfia_pkg.sv
src/lfia_ram.sv
src/lfia_dp.sv
src/lfia_ctrl.sv
src/lowest_free_id_allocator_core.sv
tb/sv/tb.sv
